// ===== rtl/core/timestamped_sample_ring_buffer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the timestamped sample ring buffer
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_SAMPLE_RING_BUFFER_ASSERT_SVH
`define TIMESTAMPED_SAMPLE_RING_BUFFER_ASSERT_SVH

// Same-cycle implication.
`define TSRB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TSRB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tsrb_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrb_pkg
// Shared constants, widths and types of the timestamped sample ring buffer.
// ----------------------------------------------------------------------------
package tsrb_pkg;

	localparam int CAPACITY       = 32768;
	localparam int PTR_W          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W          = PTR_W + 1;
	localparam int OFS_W          = 15;
	localparam int AMT_W          = 16;
	localparam int SUM_W          = ((PTR_W > OFS_W) ? PTR_W : OFS_W) + 1;
	localparam int OFS_CMP_W      = (CNT_W > OFS_W) ? CNT_W : OFS_W;
	localparam int AMT_CMP_W      = (CNT_W > AMT_W) ? CNT_W : AMT_W;
	localparam int STEP_W         = CNT_W + 6;
	localparam int SAMPLE_STEP_US = 62;

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = 1;
	localparam int QCNT_W  = 2;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_READ   = 2'd1,
		OP_DRAIN  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] sample;
		logic signed [63:0] time_us;
		logic [OFS_W-1:0]   offset;
		logic [AMT_W-1:0]   amount;
	} req_t;

endpackage

// ===== rtl/core/tsrb_front.sv =====
// ----------------------------------------------------------------------------
// tsrb_front
// Accepts requests, decodes the operation and queues them for the back end.
// ----------------------------------------------------------------------------
module tsrb_front import tsrb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [15:0] sample_in,
	input  logic signed [63:0] time_in_us,
	input  logic [14:0]        read_offset,
	input  logic [15:0]        drain_amount,
	output logic               req_valid,
	output req_t               req,
	input  logic               req_pop
);

	req_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;
	req_t              req_in;

	assign in_stall  = (count_q == QCNT_W'(QDEPTH));
	assign push      = in_valid && !in_stall;
	assign req_valid = (count_q != '0);
	assign pop       = req_pop && req_valid;
	assign req       = entry_q[rd_ptr_q];

	always_comb begin
		req_in.op      = op_t'(operation);
		req_in.sample  = sample_in;
		req_in.time_us = time_in_us;
		req_in.offset  = read_offset;
		req_in.amount  = drain_amount;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/tsrb_back.sv =====
// ----------------------------------------------------------------------------
// tsrb_back
// Executes queued requests: sample store, pointers, start time, drop count
// and the result register.
// ----------------------------------------------------------------------------
module tsrb_back import tsrb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  req_t               req,
	output logic               req_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample_out,
	output logic               sample_valid,
	output logic signed [63:0] start_time_us,
	output logic [15:0]        fill_count,
	output logic [31:0]        dropped_total,
	output logic [15:0]        drained_count
);

	logic signed [15:0] sample_store [CAPACITY];

	logic [PTR_W-1:0]   wp_q;
	logic [PTR_W-1:0]   tail_q;
	logic [CNT_W-1:0]   count_q;
	logic [63:0]        start_q;
	logic               half_q;
	logic [31:0]        drop_q;

	logic               out_valid_q;
	logic signed [15:0] rdata_q;
	logic               valid_q;
	logic [63:0]        time_q;
	logic [15:0]        fill_q;
	logic [CNT_W-1:0]   drained_q;

	logic               exec;
	logic               full;
	logic               capture;
	logic [63:0]        base_time;
	logic               base_half;
	logic [63:0]        app_time;
	logic [PTR_W-1:0]   wp_next;
	logic [PTR_W-1:0]   tail_next;
	logic [SUM_W-1:0]   rd_sum;
	logic [PTR_W-1:0]   rd_idx;
	logic               rd_hit;
	logic               dr_do;
	logic [CNT_W-1:0]   dr_n;
	logic               dr_empty;
	logic [CNT_W:0]     dr_halves;
	logic [STEP_W-1:0]  dr_step;
	logic [CNT_W-1:0]   dr_tail_sum;
	logic [PTR_W-1:0]   dr_tail;

	// Execute when the result slot is free or is taken this cycle.
	assign exec    = req_valid && (!out_valid_q || !out_stall);
	assign req_pop = exec;

	assign full    = (count_q == CNT_W'(CAPACITY));
	assign capture = (count_q == '0) || start_q[63];

	always_comb begin
		base_time = capture ? req.time_us : start_q;
		base_half = capture ? 1'b0 : half_q;
		app_time  = full ? base_time + 64'(SAMPLE_STEP_US) + 64'(base_half) : base_time;
		wp_next   = (wp_q == PTR_W'(CAPACITY - 1)) ? '0 : wp_q + 1'b1;
		tail_next = (tail_q == PTR_W'(CAPACITY - 1)) ? '0 : tail_q + 1'b1;

		rd_sum = SUM_W'(tail_q) + SUM_W'(req.offset);
		rd_idx = (rd_sum >= SUM_W'(CAPACITY)) ? PTR_W'(rd_sum - SUM_W'(CAPACITY))
		                                      : PTR_W'(rd_sum);
		rd_hit = OFS_CMP_W'(req.offset) < OFS_CMP_W'(count_q);

		dr_do    = (req.amount != '0) && (count_q != '0);
		dr_n     = (AMT_CMP_W'(req.amount) < AMT_CMP_W'(count_q)) ? CNT_W'(req.amount)
		                                                          : count_q;
		dr_empty = (dr_n == count_q);
		// Carry the half microsecond of each 62.5 us step exactly.
		dr_halves   = (CNT_W + 1)'(half_q) + (CNT_W + 1)'(dr_n);
		dr_step     = STEP_W'(dr_n) * STEP_W'(SAMPLE_STEP_US) + STEP_W'(dr_halves >> 1);
		dr_tail_sum = CNT_W'(tail_q) + dr_n;
		dr_tail     = (dr_tail_sum >= CNT_W'(CAPACITY))
		            ? PTR_W'(dr_tail_sum - CNT_W'(CAPACITY)) : PTR_W'(dr_tail_sum);
	end

	// Sample store: at most one write (appends only) and one registered read per request.
	always_ff @(posedge clk) begin
		if (exec && req.op == OP_APPEND) begin
			sample_store[wp_q] <= req.sample;
		end
		if (exec) begin
			rdata_q <= sample_store[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			start_q     <= '1;
			half_q      <= 1'b0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (exec) begin
				unique case (req.op)
					OP_APPEND: begin
						start_q <= app_time;
						wp_q    <= wp_next;
						if (full) begin
							half_q <= ~base_half;
							tail_q <= tail_next;
							if (drop_q != '1) begin
								drop_q <= drop_q + 1'b1;
							end
						end else begin
							half_q  <= base_half;
							count_q <= count_q + 1'b1;
						end
					end
					OP_READ: begin
					end
					OP_DRAIN: begin
						if (dr_do) begin
							if (dr_empty) begin
								wp_q    <= '0;
								tail_q  <= '0;
								count_q <= '0;
								start_q <= '1;
								half_q  <= 1'b0;
							end else begin
								count_q <= count_q - dr_n;
								tail_q  <= dr_tail;
								start_q <= start_q + 64'(dr_step);
								half_q  <= dr_halves[0];
							end
						end
					end
					OP_CLEAR: begin
						wp_q    <= '0;
						tail_q  <= '0;
						count_q <= '0;
						start_q <= '1;
						half_q  <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result payload, captured with the state it reports.
	always_ff @(posedge clk) begin
		if (exec) begin
			valid_q   <= (req.op == OP_READ) && rd_hit;
			drained_q <= (req.op == OP_DRAIN && dr_do) ? dr_n : '0;
			unique case (req.op)
				OP_APPEND: begin
					time_q <= app_time;
					fill_q <= full ? 16'(count_q) : 16'(count_q + 1'b1);
				end
				OP_READ: begin
					time_q <= start_q;
					fill_q <= 16'(count_q);
				end
				OP_DRAIN: begin
					if (dr_do && dr_empty) begin
						time_q <= '1;
						fill_q <= '0;
					end else if (dr_do) begin
						time_q <= start_q + 64'(dr_step);
						fill_q <= 16'(count_q - dr_n);
					end else begin
						time_q <= start_q;
						fill_q <= 16'(count_q);
					end
				end
				OP_CLEAR: begin
					time_q <= '1;
					fill_q <= '0;
				end
				default: begin
					time_q <= start_q;
					fill_q <= 16'(count_q);
				end
			endcase
		end
	end

	// drop_q already holds the count that includes this request's overwrite.
	assign out_valid     = out_valid_q;
	assign sample_valid  = valid_q;
	assign sample_out    = valid_q ? rdata_q : 16'sd0;
	assign start_time_us = time_q;
	assign fill_count    = fill_q;
	assign dropped_total = drop_q;
	assign drained_count = 16'(drained_q);

endmodule

// ===== rtl/core/timestamped_sample_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// timestamped_sample_ring_buffer
// Overwriting ring buffer of Q1.15 samples with a start timestamp.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | operation, sample_in, time_in_us,
//           |                      | read_offset, drain_amount
//   out     | out_valid / out_stall| sample_out, sample_valid, start_time_us,
//           |                      | fill_count, dropped_total, drained_count
//
// One request per cycle sustained while out_stall stays low; each accepted
// request makes one result after passing a queue slot and then an execute
// step with at most one store write and a registered read.
// Reset clears pointers, counters and start time at once; the sample store is
// not cleared and holds whatever it held until written.
// A stalled result holds the back end; the two-entry queue keeps taking
// requests until it fills, then in_stall rises.
// ----------------------------------------------------------------------------
module timestamped_sample_ring_buffer import tsrb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [15:0] sample_in,
	input  logic signed [63:0] time_in_us,
	input  logic [14:0]        read_offset,
	input  logic [15:0]        drain_amount,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample_out,
	output logic               sample_valid,
	output logic signed [63:0] start_time_us,
	output logic [15:0]        fill_count,
	output logic [31:0]        dropped_total,
	output logic [15:0]        drained_count
);

	logic req_valid;
	req_t req;
	logic req_pop;

	tsrb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.sample_in    (sample_in),
		.time_in_us   (time_in_us),
		.read_offset  (read_offset),
		.drain_amount (drain_amount),
		.req_valid    (req_valid),
		.req          (req),
		.req_pop      (req_pop)
	);

	tsrb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req           (req),
		.req_pop       (req_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_out    (sample_out),
		.sample_valid  (sample_valid),
		.start_time_us (start_time_us),
		.fill_count    (fill_count),
		.dropped_total (dropped_total),
		.drained_count (drained_count)
	);

endmodule

// ===== rtl/core/tsrb_checker.sv =====
// ----------------------------------------------------------------------------
// tsrb_checker
// Port-level checks on the results of the timestamped sample ring buffer.
// ----------------------------------------------------------------------------
`include "timestamped_sample_ring_buffer_assert.svh"

module tsrb_checker import tsrb_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] sample_out,
	input logic               sample_valid,
	input logic signed [63:0] start_time_us,
	input logic [15:0]        fill_count,
	input logic [15:0]        drained_count
);

	// Hold a stalled result.
	`TSRB_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(sample_out) && $stable(start_time_us) && $stable(fill_count),
		"stalled result changed")

	// Drop sample data outside a valid read.
	`TSRB_ASSERT_NOW(a_sample_zero, out_valid && !sample_valid, sample_out == 16'sd0,
		"sample_out nonzero without sample_valid")

	// An empty buffer reports no start time.
	`TSRB_ASSERT_NOW(a_empty_time, out_valid && (CAPACITY < 65536) && (fill_count == 16'd0),
		start_time_us == 64'shFFFF_FFFF_FFFF_FFFF, "empty buffer with a start time")

	// A drain never returns a sample.
	`TSRB_ASSERT_NOW(a_drain_no_read, out_valid && (drained_count != 16'd0), !sample_valid,
		"drain result flagged a read")

endmodule

bind timestamped_sample_ring_buffer tsrb_checker u_tsrb_checker (.*);
